>>> rtl/core/lncd_pkg.sv
// Package for the note colour envelope: item types, phase and kind codes, colour table.
`default_nettype none

package lncd_pkg;

	localparam int unsigned HOLD_TICKS = 15;
	localparam int unsigned END_TICKS  = 50;
	localparam int unsigned CHANNELS   = 4;
	localparam int unsigned LEVEL_W    = 11;
	localparam int unsigned COUNT_W    = 6;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_BLUE  = 1;
	localparam int unsigned CH_GREEN = 2;
	localparam int unsigned CH_LEVEL = 3;

	typedef logic [LEVEL_W-1:0] level_t;
	typedef level_t [CHANNELS-1:0] levels_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		KIND_TOUCH   = 2'd0,
		KIND_RELEASE = 2'd1,
		KIND_TICK    = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_TOUCH = 2'd1,
		PH_DECAY = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  note;
	} in_item_t;

	typedef struct packed {
		level_t red;
		level_t blue;
		level_t green;
		level_t level;
		logic   changed;
		phase_t phase;
		count_t decay_count;
	} out_item_t;

	function automatic levels_t pack_levels(input level_t r, input level_t b,
			input level_t g, input level_t l);
		levels_t v;
		v[CH_RED]   = r;
		v[CH_BLUE]  = b;
		v[CH_GREEN] = g;
		v[CH_LEVEL] = l;
		return v;
	endfunction

	// The note is reduced modulo 12 through a reciprocal multiply; exact for eight-bit notes.
	function automatic levels_t note_color(input logic [7:0] note);
		logic [18:0] prod;
		logic [4:0]  quot;
		logic [8:0]  times12;
		logic [3:0]  rem;
		levels_t     v;
		prod    = {11'd0, note} * 19'd171;
		quot    = prod[15:11];
		times12 = {4'd0, quot} * 9'd12;
		rem     = 4'(note - times12[7:0]);
		unique case (rem)
			4'd0:    v = pack_levels(11'd2000, 11'd0,    11'd0,    11'd2000);
			4'd1:    v = pack_levels(11'd1850, 11'd0,    11'd250,  11'd2000);
			4'd2:    v = pack_levels(11'd1700, 11'd0,    11'd500,  11'd2000);
			4'd3:    v = pack_levels(11'd1300, 11'd0,    11'd750,  11'd2000);
			4'd4:    v = pack_levels(11'd1000, 11'd0,    11'd1000, 11'd2000);
			4'd5:    v = pack_levels(11'd0,    11'd0,    11'd2000, 11'd2000);
			4'd6:    v = pack_levels(11'd0,    11'd1500, 11'd1500, 11'd2000);
			4'd7:    v = pack_levels(11'd0,    11'd2000, 11'd0,    11'd2000);
			4'd8:    v = pack_levels(11'd200,  11'd1800, 11'd0,    11'd2000);
			4'd9:    v = pack_levels(11'd500,  11'd1500, 11'd0,    11'd2000);
			4'd10:   v = pack_levels(11'd800,  11'd1000, 11'd0,    11'd2000);
			4'd11:   v = pack_levels(11'd1200, 11'd300,  11'd0,    11'd2000);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/led_note_color_decay.sv
// Top level of the note colour envelope: input register, envelope update and result register.
//
//  channel | beat     | handshake                   | payload
//  item    | consumed | item_valid / item_ready     | item   (kind, note)
//  result  | produced | result_valid / result_ready | result (levels, changed, phase, count)
//
// Every item yields one result in the result register; one item per cycle when not stalled.
// The envelope state is updated in the same cycle as the result register is loaded.
// Reset clears the phase, the tick count and all stored and shown levels to zero.
// A stalled result holds the input register, and item_ready falls only once both are full.
`default_nettype none

module led_note_color_decay (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  lncd_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output lncd_pkg::out_item_t  result
);
	import lncd_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      advance;

	phase_t    phase_q, phase_d;
	count_t    tick_q, tick_d, tick_inc;
	levels_t   store_q, store_d, shown_q, shown_d, scaled;
	logic      changed_d;
	logic      result_valid_q;
	out_item_t result_q;

	assign advance    = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;
	assign tick_inc   = tick_q + count_t'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	lncd_scale u_scale (
		.cur (store_q),
		.nxt (scaled)
	);

	// Next phase and tick count.
	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		unique case (item_s1.kind)
			KIND_TOUCH: begin
				phase_d = PH_TOUCH;
				tick_d  = '0;
			end
			KIND_RELEASE: begin
				phase_d = PH_DECAY;
				tick_d  = '0;
			end
			KIND_TICK: begin
				if (phase_q == PH_DECAY) begin
					if (tick_inc >= count_t'(END_TICKS)) begin
						phase_d = PH_IDLE;
						tick_d  = '0;
					end else begin
						tick_d = tick_inc;
					end
				end
			end
			default: ;
		endcase
	end

	// Stored and shown levels.
	always_comb begin
		store_d   = store_q;
		shown_d   = shown_q;
		changed_d = 1'b0;
		unique case (item_s1.kind)
			KIND_TOUCH: begin
				store_d   = note_color(item_s1.note);
				shown_d   = store_d;
				changed_d = 1'b1;
			end
			KIND_TICK: begin
				if (phase_q == PH_DECAY) begin
					if (tick_inc >= count_t'(END_TICKS)) begin
						shown_d   = '0;
						changed_d = 1'b1;
					end else if (tick_inc > count_t'(HOLD_TICKS)) begin
						store_d   = scaled;
						shown_d   = scaled;
						changed_d = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			tick_q         <= '0;
			store_q        <= '0;
			shown_q        <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				phase_q        <= phase_d;
				tick_q         <= tick_d;
				store_q        <= store_d;
				shown_q        <= shown_d;
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.red         <= shown_d[CH_RED];
			result_q.blue        <= shown_d[CH_BLUE];
			result_q.green       <= shown_d[CH_GREEN];
			result_q.level       <= shown_d[CH_LEVEL];
			result_q.changed     <= changed_d;
			result_q.phase       <= phase_d;
			result_q.decay_count <= (phase_d == PH_DECAY) ? tick_d : '0;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// Outside the decay phase the tick count is always zero.
	a_count_idle: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_DECAY |-> tick_q == '0)
		else $error("tick count nonzero outside decay");

	// A touch beat always produces a changed result in the touched phase.
	a_touch_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.kind == KIND_TOUCH |=>
			result_valid && result.changed && result.phase == PH_TOUCH)
		else $error("touch beat gave wrong result");

	// The count never reaches the end limit while decaying.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DECAY |-> tick_q < count_t'(END_TICKS))
		else $error("decay count reached end limit");

endmodule

`default_nettype wire

>>> rtl/core/lncd_scale.sv
// Scales each of the four channel levels to floor(level*9/10).
`default_nettype none

module lncd_scale (
	input  lncd_pkg::levels_t cur,
	output lncd_pkg::levels_t nxt
);
	import lncd_pkg::*;

	// floor(9x/10) equals x - ceil(x/10); ceil(x/10) is floor((x+9)/10) by reciprocal.
	always_comb begin
		for (int c = 0; c < CHANNELS; c++) begin
			logic [11:0] biased;
			logic [24:0] prod;
			biased = {1'b0, cur[c]} + 12'd9;
			prod   = {13'd0, biased} * 25'd6554;
			nxt[c] = cur[c] - level_t'(prod[24:16]);
		end
	end

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Testbench for the note colour envelope: random-paced beats checked against a built-in envelope predictor.
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lncd_pkg::*;

	localparam kind_t KIND_UNUSED = kind_t'(2'd3);
	localparam int unsigned ITEM_TARGET = 1150;
	localparam int unsigned NOTE_COLOURS = 12;

	localparam int unsigned COLOUR_TABLE [NOTE_COLOURS][CHANNELS] = '{
		'{2000, 0,    0,    2000},
		'{1850, 0,    250,  2000},
		'{1700, 0,    500,  2000},
		'{1300, 0,    750,  2000},
		'{1000, 0,    1000, 2000},
		'{0,    0,    2000, 2000},
		'{0,    1500, 1500, 2000},
		'{0,    2000, 0,    2000},
		'{200,  1800, 0,    2000},
		'{500,  1500, 0,    2000},
		'{800,  1000, 0,    2000},
		'{1200, 300,  0,    2000}
	};

	logic      clk;
	logic      arst_n;
	logic      item_valid;
	logic      item_ready;
	in_item_t  item;
	logic      result_valid;
	logic      result_ready;
	out_item_t result;

	phase_t env_phase = PH_IDLE;
	count_t env_count = '0;
	level_t stored_levels [CHANNELS] = '{default: '0};
	level_t shown_levels [CHANNELS] = '{default: '0};

	out_item_t   expected_results [$];
	int unsigned items_sent = 0;
	int unsigned fail_count = 0;
	int          sender_burst = 0;
	int          receiver_burst = 0;

	led_note_color_decay dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(5, 40);
			return 0;
		end
		return $urandom_range(0, 19);
	endfunction

	function automatic out_item_t predict_envelope(input kind_t k, input logic [7:0] note);
		out_item_t   r;
		logic        changed;
		int unsigned idx;
		changed = 1'b0;
		case (k)
			KIND_TOUCH: begin
				idx = note % NOTE_COLOURS;
				env_phase = PH_TOUCH;
				env_count = '0;
				for (int c = 0; c < CHANNELS; c++) begin
					stored_levels[c] = level_t'(COLOUR_TABLE[idx][c]);
					shown_levels[c] = stored_levels[c];
				end
				changed = 1'b1;
			end
			KIND_RELEASE: begin
				env_phase = PH_DECAY;
				env_count = '0;
			end
			KIND_TICK: begin
				if (env_phase == PH_DECAY) begin
					env_count = env_count + 1'b1;
					if (env_count > HOLD_TICKS && env_count < END_TICKS) begin
						for (int c = 0; c < CHANNELS; c++) begin
							stored_levels[c] = level_t'((32'(stored_levels[c]) * 9) / 10);
							shown_levels[c] = stored_levels[c];
						end
						changed = 1'b1;
					end else if (env_count >= END_TICKS) begin
						for (int c = 0; c < CHANNELS; c++)
							shown_levels[c] = '0;
						env_phase = PH_IDLE;
						env_count = '0;
						changed = 1'b1;
					end
				end
			end
			default: ;
		endcase
		r.red = shown_levels[CH_RED];
		r.blue = shown_levels[CH_BLUE];
		r.green = shown_levels[CH_GREEN];
		r.level = shown_levels[CH_LEVEL];
		r.changed = changed;
		r.phase = env_phase;
		r.decay_count = (env_phase == PH_DECAY) ? env_count : '0;
		return r;
	endfunction

	task automatic send_beat(input kind_t k, input logic [7:0] note);
		int gap;
		gap = draw_wait(sender_burst);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{kind: k, note: note};
		do @(posedge clk); while (!item_ready);
		expected_results.push_back(predict_envelope(k, note));
		if (k != KIND_UNUSED)
			items_sent++;
	endtask

	task automatic report_mismatch(input string field, input int unsigned exp_v,
			input int unsigned got_v);
		$display("%0t ns: %s expected %0d actual %0d", $time, field, exp_v, got_v);
		fail_count++;
	endtask

	task automatic check_result(input out_item_t got);
		out_item_t exp_r;
		if (expected_results.size() == 0) begin
			$display("%0t ns: result beat with none expected, actual %h", $time, got);
			fail_count++;
			return;
		end
		exp_r = expected_results.pop_front();
		if (got.red !== exp_r.red)
			report_mismatch("red", exp_r.red, got.red);
		if (got.blue !== exp_r.blue)
			report_mismatch("blue", exp_r.blue, got.blue);
		if (got.green !== exp_r.green)
			report_mismatch("green", exp_r.green, got.green);
		if (got.level !== exp_r.level)
			report_mismatch("level", exp_r.level, got.level);
		if (got.changed !== exp_r.changed)
			report_mismatch("changed", exp_r.changed, got.changed);
		if (got.phase !== exp_r.phase)
			report_mismatch("phase", exp_r.phase, got.phase);
		if (got.decay_count !== exp_r.decay_count)
			report_mismatch("decay_count", exp_r.decay_count, got.decay_count);
	endtask

	task automatic test_quiet_from_reset();
		send_beat(KIND_TICK, 8'hFF);
		send_beat(KIND_UNUSED, 8'h00);
		send_beat(KIND_RELEASE, 8'hA5);
		send_beat(KIND_TICK, 8'h5A);
	endtask

	task automatic test_colour_table();
		for (int n = 0; n < NOTE_COLOURS; n++)
			send_beat(KIND_TOUCH, 8'(n));
		send_beat(KIND_TOUCH, 8'd255);
		send_beat(KIND_TOUCH, 8'd12);
		send_beat(KIND_TICK, 8'd0);
	endtask

	task automatic test_release_and_retouch();
		send_beat(KIND_RELEASE, 8'd3);
		send_beat(KIND_TICK, 8'd77);
		send_beat(KIND_TICK, 8'd200);
		send_beat(KIND_RELEASE, 8'd0);
		send_beat(KIND_TICK, 8'd1);
		send_beat(KIND_TOUCH, 8'd100);
		send_beat(KIND_UNUSED, 8'hFF);
	endtask

	task automatic test_random_envelopes();
		int pick;
		int ticks;
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 9);
			if (pick == 9) begin
				repeat ($urandom_range(1, 6))
					send_beat(kind_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end else begin
				send_beat(KIND_TOUCH, 8'($urandom_range(0, 255)));
				repeat ($urandom_range(0, 3))
					send_beat(KIND_TICK, 8'($urandom_range(0, 255)));
				send_beat(KIND_RELEASE, 8'($urandom_range(0, 255)));
				if (pick < 6)
					ticks = $urandom_range(END_TICKS, END_TICKS + 4);
				else
					ticks = $urandom_range(1, END_TICKS - 1);
				repeat (ticks)
					send_beat(KIND_TICK, 8'($urandom_range(0, 255)));
				if (pick == 5 || pick == 7) begin
					send_beat(KIND_RELEASE, 8'($urandom_range(0, 255)));
					repeat (END_TICKS)
						send_beat(KIND_TICK, 8'($urandom_range(0, 255)));
				end else if (pick == 6) begin
					send_beat(KIND_UNUSED, 8'($urandom_range(0, 255)));
				end
			end
		end
	endtask

	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = draw_wait(receiver_burst);
			if (stall > 0) begin
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ready <= 1'b1;
			do @(posedge clk); while (!result_valid);
			check_result(result);
		end
	end

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_quiet_from_reset();
		test_colour_table();
		test_release_and_retouch();
		test_random_envelopes();
		item_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("%0t ns: timeout", $time);
		$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire

>>> sim.f
rtl/core/lncd_pkg.sv
rtl/core/lncd_scale.sv
rtl/core/led_note_color_decay.sv
dv/tb_top.sv
